// ===== rtl/core/grtt_pkg.sv =====
// ---------------------------------------------------------------------------
// grtt_pkg
// Shared types and constants of the guest region translation table.
// ---------------------------------------------------------------------------
package grtt_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int USED_W  = 7;
   localparam int GA_W    = 52;
   localparam int HA_W    = 64;
   localparam int LEN_W   = 53;

   typedef enum logic [1:0] {
      CMD_REMEMBER = 2'd0,
      CMD_FORGET   = 2'd1,
      CMD_LOOKUP   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_APPENDED = 3'd1,
      ST_DROPPED  = 3'd2,
      ST_REMOVED  = 3'd3,
      ST_ABSENT   = 3'd4,
      ST_HIT      = 3'd5,
      ST_MISS     = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LAST_RD,
      S_MOVE,
      S_XLATE,
      S_RESP
   } state_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [GA_W-1:0]   guest_address;
      logic [HA_W-1:0]   host_base;
      logic [LEN_W-1:0]  region_size;
      logic [LEN_W-1:0]  access_length;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [HA_W-1:0]   host_address;
      logic [USED_W-1:0] entries_used;
   } rsp_type;

   typedef struct packed {
      logic [GA_W-1:0]   guest_base;
      logic [HA_W-1:0]   host_base;
      logic [LEN_W-1:0]  length;
   } entry_type;

   typedef struct packed {
      logic              base_eq;
      logic              covers;
      logic [GA_W-1:0]   offset;
   } match_type;

endpackage

// ===== rtl/core/grtt_ram.sv =====
// ---------------------------------------------------------------------------
// grtt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module grtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/grtt_match.sv =====
// ---------------------------------------------------------------------------
// grtt_match
// Compare one stored region against the held request.
// ---------------------------------------------------------------------------
module grtt_match (
   input  grtt_pkg::entry_type entry,
   input  grtt_pkg::req_type   req,
   output grtt_pkg::match_type result
);

   logic [grtt_pkg::LEN_W:0] req_end;
   logic [grtt_pkg::LEN_W:0] region_end;

   always_comb begin
      // full-width ends, no wrap
      req_end    = {2'b00, req.guest_address} + {1'b0, req.access_length};
      region_end = {2'b00, entry.guest_base} + {1'b0, entry.length};
      result.base_eq = (entry.guest_base == req.guest_address);
      result.covers  = (req.guest_address >= entry.guest_base) && (req_end <= region_end);
      result.offset  = req.guest_address - entry.guest_base;
   end

endmodule

// ===== rtl/core/guest_region_translation_table.sv =====
// ---------------------------------------------------------------------------
// guest_region_translation_table
// Region table with remember, forget and lookup requests over one RAM.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one request (cmd, guest_address, host_base, region_size,
//   access_length) under valid/ready; rsp_* returns exactly one response
//   (status, host_address, entries_used) per request, in order.
//   All regions live in one RAM with a registered read. Every
//   request except the unused command code walks the valid slots in order,
//   one RAM read per cycle, with the compare in the cycle after the read.
//   The time from accept to rsp_valid grows with the slots scanned; a forget
//   that hits adds a read and a write of the last slot, a lookup hit adds a
//   step to form the host address. The worst case is a forget that hits the
//   last slot. One request is in flight at a time; req_ready is high while
//   the block is idle, also while an earlier response waits, so a new request
//   is taken only once the last has left the response state.
//   Reset clears the slot count and the other control state only; the RAM
//   needs no clearing pass since only slots below the count are ever read.
//   When rsp_ready stays low the finished response holds in the output
//   register, and a following request stalls before its result is loaded.
// ---------------------------------------------------------------------------
module guest_region_translation_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  grtt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output grtt_pkg::rsp_type rsp_data
);

   localparam int IDX_W  = grtt_pkg::IDX_W;
   localparam int CNT_W  = grtt_pkg::CNT_W;
   localparam int USED_W = grtt_pkg::USED_W;
   localparam int GA_W   = grtt_pkg::GA_W;
   localparam int HA_W   = grtt_pkg::HA_W;

   // control state
   grtt_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    used_count_ff, used_count_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                pend_vld_ff, pend_vld_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload state
   grtt_pkg::req_type   req_ff, req_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   grtt_pkg::status_type status_ff, status_in;
   logic [HA_W-1:0]     hit_host_ff, hit_host_in;
   logic [GA_W-1:0]     off_ff, off_in;
   logic [HA_W-1:0]     haddr_ff, haddr_in;
   grtt_pkg::rsp_type   rsp_ff, rsp_in;

   // RAM ports
   logic                ram_we;
   logic [IDX_W-1:0]    ram_wr_addr;
   grtt_pkg::entry_type ram_wr_data;
   logic [IDX_W-1:0]    ram_rd_addr;
   grtt_pkg::entry_type ram_rd_data;

   grtt_pkg::match_type match;

   logic                req_fire;
   logic                rsp_free;
   logic                pend_hit;
   logic                scan_more;
   logic                scan_miss;
   logic                table_full;
   logic [CNT_W-1:0]    last_cnt;
   logic [CNT_W+USED_W-1:0] used_wide;

   grtt_ram #(
      .WIDTH ($bits(grtt_pkg::entry_type)),
      .DEPTH (grtt_pkg::ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   grtt_match u_match (
      .entry  (ram_rd_data),
      .req    (req_ff),
      .result (match)
   );

   // Scan status: data of the read issued last cycle is on ram_rd_data now.
   assign req_ready  = (state_ff == grtt_pkg::S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign scan_more  = (rd_idx_ff < used_count_ff);
   assign pend_hit   = pend_vld_ff &&
                       ((req_ff.cmd == grtt_pkg::CMD_LOOKUP) ? match.covers : match.base_eq);
   assign scan_miss  = !pend_vld_ff && !scan_more;
   assign table_full = (used_count_ff == CNT_W'(grtt_pkg::ENTRIES));
   assign last_cnt   = used_count_ff - CNT_W'(1);
   assign used_wide  = {{USED_W{1'b0}}, used_count_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         grtt_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == grtt_pkg::CMD_REMEMBER || req_data.cmd == grtt_pkg::CMD_FORGET ||
                   req_data.cmd == grtt_pkg::CMD_LOOKUP) begin
                  state_in = grtt_pkg::S_SCAN;
               end else begin
                  state_in = grtt_pkg::S_RESP;
               end
            end
         end
         grtt_pkg::S_SCAN: begin
            if (pend_hit) begin
               unique case (req_ff.cmd)
                  grtt_pkg::CMD_FORGET: state_in = grtt_pkg::S_LAST_RD;
                  grtt_pkg::CMD_LOOKUP: state_in = grtt_pkg::S_XLATE;
                  default:              state_in = grtt_pkg::S_RESP;
               endcase
            end else if (scan_miss) begin
               state_in = grtt_pkg::S_RESP;
            end
         end
         grtt_pkg::S_LAST_RD: state_in = grtt_pkg::S_MOVE;
         grtt_pkg::S_MOVE:    state_in = grtt_pkg::S_RESP;
         grtt_pkg::S_XLATE:   state_in = grtt_pkg::S_RESP;
         grtt_pkg::S_RESP: begin
            if (rsp_free) begin
               state_in = grtt_pkg::S_IDLE;
            end
         end
         default: state_in = grtt_pkg::S_IDLE;
      endcase
   end

   // RAM controls
   always_comb begin
      ram_we      = 1'b0;
      ram_wr_addr = pend_idx_ff;
      ram_wr_data = '{guest_base: req_ff.guest_address,
                      host_base:  req_ff.host_base,
                      length:     req_ff.region_size};
      ram_rd_addr = rd_idx_ff[IDX_W-1:0];
      unique case (state_ff)
         grtt_pkg::S_SCAN: begin
            // remember: overwrite the matching slot, or append at the end
            if (req_ff.cmd == grtt_pkg::CMD_REMEMBER) begin
               if (pend_hit) begin
                  ram_we = 1'b1;
               end else if (scan_miss && !table_full) begin
                  ram_we      = 1'b1;
                  ram_wr_addr = used_count_ff[IDX_W-1:0];
               end
            end
         end
         grtt_pkg::S_LAST_RD: begin
            ram_rd_addr = last_cnt[IDX_W-1:0];
         end
         grtt_pkg::S_MOVE: begin
            // move the last slot into the hole
            ram_we      = 1'b1;
            ram_wr_addr = slot_ff;
            ram_wr_data = ram_rd_data;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      req_in        = req_ff;
      used_count_in = used_count_ff;
      rd_idx_in     = rd_idx_ff;
      pend_vld_in   = 1'b0;
      pend_idx_in   = rd_idx_ff[IDX_W-1:0];
      slot_in       = slot_ff;
      status_in     = status_ff;
      hit_host_in   = hit_host_ff;
      off_in        = off_ff;
      haddr_in      = haddr_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         grtt_pkg::S_IDLE: begin
            if (req_fire) begin
               req_in    = req_data;
               rd_idx_in = '0;
               haddr_in  = '0;
               status_in = grtt_pkg::ST_MISS;
            end
         end
         grtt_pkg::S_SCAN: begin
            if (pend_hit) begin
               slot_in     = pend_idx_ff;
               hit_host_in = ram_rd_data.host_base;
               off_in      = match.offset;
               if (req_ff.cmd == grtt_pkg::CMD_REMEMBER) begin
                  status_in = grtt_pkg::ST_UPDATED;
               end
            end else if (scan_miss) begin
               case (req_ff.cmd)
                  grtt_pkg::CMD_REMEMBER: begin
                     if (table_full) begin
                        status_in = grtt_pkg::ST_DROPPED;
                     end else begin
                        status_in     = grtt_pkg::ST_APPENDED;
                        used_count_in = used_count_ff + CNT_W'(1);
                     end
                  end
                  grtt_pkg::CMD_FORGET: status_in = grtt_pkg::ST_ABSENT;
                  default:              status_in = grtt_pkg::ST_MISS;
               endcase
            end else if (scan_more) begin
               // issue the next slot read
               pend_vld_in = 1'b1;
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
            end
         end
         grtt_pkg::S_MOVE: begin
            used_count_in = last_cnt;
            status_in     = grtt_pkg::ST_REMOVED;
         end
         grtt_pkg::S_XLATE: begin
            haddr_in  = hit_host_ff + {{(HA_W-GA_W){1'b0}}, off_ff};
            status_in = grtt_pkg::ST_HIT;
         end
         grtt_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.host_address = haddr_ff;
               rsp_in.entries_used = used_wide[USED_W-1:0];
            end
         end
         default: begin
            pend_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= grtt_pkg::S_IDLE;
         used_count_ff <= '0;
         rd_idx_ff     <= '0;
         pend_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_count_ff <= used_count_in;
         rd_idx_ff     <= rd_idx_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      hit_host_ff <= hit_host_in;
      off_ff      <= off_in;
      haddr_ff    <= haddr_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= CNT_W'(grtt_pkg::ENTRIES))
      else $error("slot count above table depth");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == grtt_pkg::S_IDLE || state_ff == grtt_pkg::S_RESP) |-> !ram_we)
      else $error("RAM written outside of a command");

   a_move_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == grtt_pkg::S_MOVE) |-> (used_count_ff != '0))
      else $error("slot move with an empty table");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(state_ff == grtt_pkg::S_RESP))
      else $error("response raised outside of the response state");

endmodule

// ===== verif/tb_guest_region_translation_table.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_guest_region_translation_table
// Self-checking bench for the guest region translation table. A directed
// opening covers the corner cases. Random phases then fill, update, prune
// and scan the table. A shadow copy of the table predicts every response,
// and the monitor compares each response field by field, in order.
// ---------------------------------------------------------------------------
module tb_guest_region_translation_table;
   import grtt_pkg::*;

   localparam logic [1:0]  CMD_UNUSED   = 2'd3;      // code with no command behind it
   localparam logic [63:0] GA_MAX       = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [63:0] LEN_TOP      = 64'h0010_0000_0000_0000;
   localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int          RANDOM_ITEMS = 1350;
   localparam int          STORE_DEPTH  = 4096;
   localparam int          LONG_HOLD    = 500;
   localparam int          SETTLE       = ENTRIES + 20;

   typedef enum {MIX_SPARSE, MIX_CLUSTER, MIX_FILL, MIX_PRUNE} phase_mix_t;

   typedef struct {
      req_type     req;
      int unsigned gap;      // idle cycles before the request is offered
      bit          drain;    // hold the request until every response is back
   } queued_request;

   typedef struct {
      logic [63:0] base;
      logic [63:0] size;
   } region_note;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Stimulus waiting for the driver; filled once, before reset drops.
   queued_request pending_requests[$];
   region_note    region_notes[$];
   bit            sender_eager = 1'b0;
   int            total_items  = 0;

   // Shadow of the region table, advanced as each request is accepted.
   logic [GA_W-1:0]  shadow_guest_base [ENTRIES];
   logic [HA_W-1:0]  shadow_host_base  [ENTRIES];
   logic [LEN_W-1:0] shadow_length     [ENTRIES];
   int               shadow_used = 0;

   // Predicted responses in request order, indexed by request number.
   rsp_type predicted_rsp [STORE_DEPTH];
   int      requests_taken    = 0;
   int      responses_checked = 0;
   int      mismatches        = 0;

   int      idle_cycles = 0;
   int      in_flight;
   int      stall_left  = 0;
   bit      rsp_eager   = 1'b0;
   rsp_type expected_rsp;

   guest_region_translation_table DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Shadow table: apply one request and return the response it must produce.
   // -------------------------------------------------------------------------
   function automatic rsp_type predict_translation(req_type r);
      rsp_type         res;
      int              slot;
      int              last;
      logic [GA_W+2:0] span_end;
      logic [GA_W+2:0] region_end;
      res        = '0;
      res.status = ST_MISS;
      slot       = -1;
      // Remember and forget both act on the first slot with an equal base.
      for (int i = 0; i < shadow_used; i++) begin
         if (slot < 0 && shadow_guest_base[i] == r.guest_address) slot = i;
      end
      case (r.cmd)
         CMD_REMEMBER: begin
            if (slot >= 0) begin
               shadow_host_base[slot] = r.host_base;
               shadow_length[slot]    = r.region_size;
               res.status             = ST_UPDATED;
            end else if (shadow_used < ENTRIES) begin
               shadow_guest_base[shadow_used] = r.guest_address;
               shadow_host_base[shadow_used]  = r.host_base;
               shadow_length[shadow_used]     = r.region_size;
               shadow_used++;
               res.status = ST_APPENDED;
            end else begin
               res.status = ST_DROPPED;
            end
         end
         CMD_FORGET: begin
            if (slot >= 0) begin
               // Move the last valid slot into the hole.
               last                    = shadow_used - 1;
               shadow_guest_base[slot] = shadow_guest_base[last];
               shadow_host_base[slot]  = shadow_host_base[last];
               shadow_length[slot]     = shadow_length[last];
               shadow_used             = last;
               res.status              = ST_REMOVED;
            end else begin
               res.status = ST_ABSENT;
            end
         end
         CMD_LOOKUP: begin
            // Compare at full width so neither end can wrap.
            span_end = {3'b000, r.guest_address} + {2'b00, r.access_length};
            for (int i = 0; i < shadow_used; i++) begin
               region_end = {3'b000, shadow_guest_base[i]} + {2'b00, shadow_length[i]};
               if (res.status == ST_MISS && r.guest_address >= shadow_guest_base[i] &&
                   span_end <= region_end) begin
                  res.status       = ST_HIT;
                  res.host_address = shadow_host_base[i] +
                                     HA_W'(r.guest_address - shadow_guest_base[i]);
               end
            end
         end
         default: ;
      endcase
      res.entries_used = USED_W'(shadow_used);
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_upto(logic [63:0] hi);
      if (hi == ALL_ONES) return rand64();
      return rand64() % (hi + 64'd1);
   endfunction

   // Mix of empty, largest, full-range and short lengths.
   function automatic logic [63:0] pick_length();
      case ($urandom_range(0, 7))
         0:       return 64'd0;
         1:       return LEN_TOP;
         2, 3:    return rand_upto(LEN_TOP);
         default: return rand_upto(64'd1 << $urandom_range(1, 24));
      endcase
   endfunction

   function automatic void queue_request(logic [1:0] code, logic [63:0] ga, logic [63:0] hb,
                                         logic [63:0] rs, logic [63:0] al, bit drain);
      queued_request q;
      // Flip between back-to-back stretches and gapped stretches now and then.
      if ($urandom_range(0, 29) == 0) sender_eager = !sender_eager;
      q.req.cmd           = cmd_type'(code);
      q.req.guest_address = ga[GA_W-1:0];
      q.req.host_base     = hb;
      q.req.region_size   = rs[LEN_W-1:0];
      q.req.access_length = al[LEN_W-1:0];
      q.gap               = sender_eager ? 0 : $urandom_range(0, 18);
      q.drain             = drain;
      pending_requests.push_back(q);
      total_items++;
   endfunction

   function automatic int note_index(logic [63:0] base);
      foreach (region_notes[i]) begin
         if (region_notes[i].base == base) return i;
      end
      return -1;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      phase_mix_t  mix;
      logic [63:0] base_pool[$];
      logic [63:0] origin;
      logic [63:0] base;
      logic [63:0] size;
      logic [63:0] offset;
      logic [63:0] addr;
      logic [63:0] alen;
      int          pool_size;
      int          phase_len;
      int          phase_no;
      int          w_remember;
      int          w_forget;
      int          roll;
      int          idx;

      // Directed opening: empty table, update in place, region edges, empty
      // region, hole filling, first-match order.
      queue_request(CMD_LOOKUP,   64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
      queue_request(CMD_FORGET,   64'h1234, 64'd0, 64'd0, 64'd0, 1'b0);
      queue_request(CMD_UNUSED,   GA_MAX, ALL_ONES, LEN_TOP, LEN_TOP, 1'b0);
      queue_request(CMD_REMEMBER, 64'd0, ALL_ONES, 64'h1000, 64'd0, 1'b0);
      queue_request(CMD_REMEMBER, 64'd0, 64'h10, 64'h2000, 64'd0, 1'b0);
      queue_request(CMD_LOOKUP,   64'h1000, 64'd0, 64'd0, 64'h1000, 1'b0);
      queue_request(CMD_LOOKUP,   64'h2000, 64'd0, 64'd0, 64'd0, 1'b0);
      queue_request(CMD_LOOKUP,   64'h1FFF, 64'd0, 64'd0, 64'd2, 1'b0);
      queue_request(CMD_REMEMBER, GA_MAX, ALL_ONES, LEN_TOP, 64'd0, 1'b0);
      queue_request(CMD_LOOKUP,   GA_MAX, 64'd0, 64'd0, LEN_TOP, 1'b0);
      queue_request(CMD_REMEMBER, 64'h5000, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 64'd0, 1'b0);
      queue_request(CMD_LOOKUP,   64'h5800, 64'd0, 64'd0, 64'h10, 1'b0);
      queue_request(CMD_REMEMBER, 64'h9000, 64'hABCD_0000, 64'd0, 64'd0, 1'b0);
      queue_request(CMD_LOOKUP,   64'h9000, 64'd0, 64'd0, 64'd0, 1'b0);
      queue_request(CMD_LOOKUP,   64'h9000, 64'd0, 64'd0, 64'd1, 1'b0);
      queue_request(CMD_LOOKUP,   64'd0, 64'd0, 64'd0, LEN_TOP, 1'b0);
      queue_request(CMD_REMEMBER, 64'h20000, 64'h1234, 64'h100, 64'd0, 1'b0);
      queue_request(CMD_FORGET,   64'h5000, 64'd0, 64'd0, 64'd0, 1'b0);
      queue_request(CMD_LOOKUP,   64'h20010, 64'd0, 64'd0, 64'h10, 1'b0);
      queue_request(CMD_FORGET,   64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
      queue_request(CMD_FORGET,   64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
      queue_request(CMD_REMEMBER, 64'h40000, 64'hA000_0000, 64'h1000, 64'd0, 1'b0);
      queue_request(CMD_REMEMBER, 64'h40800, 64'hB000_0000, 64'h1000, 64'd0, 1'b0);
      queue_request(CMD_LOOKUP,   64'h40900, 64'd0, 64'd0, 64'h10, 1'b0);
      queue_request(CMD_UNUSED,   64'd0, 64'd0, 64'd0, 64'd0, 1'b0);

      // Random phases. Each draws a fresh pool of bases and a command mix;
      // fill phases push the table past full, prune phases empty it again.
      phase_no = 0;
      while (total_items < RANDOM_ITEMS) begin
         mix = (phase_no == 0 || phase_no == 6) ? MIX_FILL : phase_mix_t'($urandom_range(0, 3));
         base_pool.delete();
         if (mix == MIX_CLUSTER) begin
            // Tight spacing so regions overlap and slot order decides.
            pool_size = $urandom_range(4, 40);
            origin    = rand64() & 64'h000F_FFFF_FFF0_0000;
            for (int k = 0; k < pool_size; k++) base_pool.push_back(origin + k * 64'h100);
         end else begin
            pool_size = (mix == MIX_FILL) ? 80 : $urandom_range(4, 100);
            for (int k = 0; k < pool_size; k++) base_pool.push_back(rand64() & GA_MAX);
            base_pool.push_back(GA_MAX);
            base_pool.push_back(64'd0);
         end
         case (mix)
            MIX_FILL:    begin w_remember = 75; w_forget = 0;  end
            MIX_PRUNE:   begin w_remember = 10; w_forget = 60; end
            MIX_CLUSTER: begin w_remember = 40; w_forget = 20; end
            default:     begin w_remember = 35; w_forget = 25; end
         endcase
         phase_len = (mix == MIX_FILL) ? 100 : $urandom_range(40, 120);

         for (int k = 0; k < phase_len; k++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) base = rand64() & GA_MAX;
            else base = base_pool[$urandom_range(0, base_pool.size() - 1)];

            if (roll < w_remember) begin
               size = (mix == MIX_CLUSTER) ? rand_upto(64'h800) : pick_length();
               idx  = note_index(base);
               if (idx >= 0) region_notes[idx].size = size;
               else if (region_notes.size() < ENTRIES) region_notes.push_back('{base, size});
               // The first request of a phase waits for the block to drain.
               queue_request(CMD_REMEMBER, base, rand64(), size, pick_length(), k == 0);
            end else if (roll < w_remember + w_forget) begin
               if (region_notes.size() > 0 && $urandom_range(0, 9) < 7) begin
                  idx  = $urandom_range(0, region_notes.size() - 1);
                  base = region_notes[idx].base;
               end else begin
                  idx = note_index(base);
               end
               if (idx >= 0) region_notes.delete(idx);
               queue_request(CMD_FORGET, base, rand64(), pick_length(), pick_length(), k == 0);
            end else if (roll < 97) begin
               if (region_notes.size() > 0 && $urandom_range(0, 4) != 0) begin
                  // Aim inside a known region, now and then right at or past its end.
                  idx    = $urandom_range(0, region_notes.size() - 1);
                  offset = rand_upto(region_notes[idx].size);
                  if ($urandom_range(0, 7) == 0) offset = region_notes[idx].size;
                  addr = region_notes[idx].base + offset;
                  if (addr > GA_MAX) begin
                     addr   = region_notes[idx].base;
                     offset = 64'd0;
                  end
                  alen = rand_upto(region_notes[idx].size - offset);
                  if ($urandom_range(0, 7) == 0) alen = 64'd0;
                  else if ($urandom_range(0, 5) == 0) alen = alen + 64'd1;
                  if (alen > LEN_TOP) alen = LEN_TOP;
               end else begin
                  addr = rand64() & GA_MAX;
                  alen = pick_length();
               end
               queue_request(CMD_LOOKUP, addr, rand64(), pick_length(), alen, k == 0);
            end else begin
               queue_request(CMD_UNUSED, rand64(), rand64(), pick_length(), pick_length(),
                             k == 0);
            end
         end
         phase_no++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and answered, then let the block
      // sit long enough to expose any stray response.
      while (requests_taken != total_items || responses_checked != requests_taken)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Give up well past the slowest legal run.
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request driver: predict on accept, then offer the next queued request
   // once its gap has run out. Hold valid and payload while the block stalls.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_cycles = 0;
      end else begin
         in_flight = requests_taken - responses_checked;
         if (req_valid && req_ready) begin
            predicted_rsp[requests_taken] <= predict_translation(req_data);
            requests_taken <= requests_taken + 1;
            in_flight++;
            idle_cycles = 0;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && idle_cycles >= pending_requests[0].gap &&
                !(pending_requests[0].drain && in_flight != 0)) begin
               req_data  <= pending_requests[0].req;
               req_valid <= 1'b1;
               void'(pending_requests.pop_front());
            end else begin
               req_valid <= 1'b0;
               idle_cycles++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor: check each accepted response against the oldest
   // prediction, then draw a stall. Twice in the run, hold off for a long
   // stretch so the block backs up and stalls its request side.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (responses_checked >= requests_taken) begin
               $error("response with no request outstanding: status %0d", rsp_data.status);
               mismatches++;
            end else begin
               expected_rsp = predicted_rsp[responses_checked];
               if (rsp_data.status !== expected_rsp.status) begin
                  $error("status: expected %0d, got %0d", expected_rsp.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.host_address !== expected_rsp.host_address) begin
                  $error("host_address: expected %h, got %h",
                         expected_rsp.host_address, rsp_data.host_address);
                  mismatches++;
               end
               if (rsp_data.entries_used !== expected_rsp.entries_used) begin
                  $error("entries_used: expected %0d, got %0d",
                         expected_rsp.entries_used, rsp_data.entries_used);
                  mismatches++;
               end
               responses_checked <= responses_checked + 1;
            end
            if ($urandom_range(0, 39) == 0) rsp_eager = !rsp_eager;
            stall_left = rsp_eager ? 0 : $urandom_range(0, 18);
            if (responses_checked == 250 || responses_checked == 800) stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

endmodule
